>>> hw/rtl/mcc_pkg.sv
// Package for the multicycle control unit: payload types, codes and state encoding.
`default_nettype none

package mcc_pkg;

    // Opcode values recognized in decode and address calculation
    localparam logic [3:0] OP_RTYPE = 4'd0;
    localparam logic [3:0] OP_JUMP  = 4'd2;
    localparam logic [3:0] OP_ADDI  = 4'd4;
    localparam logic [3:0] OP_BEQ   = 4'd8;
    localparam logic [3:0] OP_LW    = 4'd11;
    localparam logic [3:0] OP_SW    = 4'd15;

    // ALU operation codes
    localparam logic [2:0] ALU_OP_ADD = 3'd0;
    localparam logic [2:0] ALU_OP_F2  = 3'd2;
    localparam logic [2:0] ALU_OP_F4  = 3'd4;
    localparam logic [2:0] ALU_OP_F5  = 3'd5;
    localparam logic [2:0] ALU_OP_SUB = 3'd6;

    // ALU operand B sources
    localparam logic [1:0] SRCB_REG = 2'd0;
    localparam logic [1:0] SRCB_ONE = 2'd1;
    localparam logic [1:0] SRCB_IMM = 2'd2;

    // Next PC sources
    localparam logic [1:0] PCS_ALU    = 2'd0;
    localparam logic [1:0] PCS_BRANCH = 2'd1;
    localparam logic [1:0] PCS_JUMP   = 2'd2;

    // Controller states, one-hot
    typedef enum logic [10:0] {
        ST_FETCH  = 11'b000_0000_0001,
        ST_DECODE = 11'b000_0000_0010,
        ST_ADDR   = 11'b000_0000_0100,
        ST_LW_MEM = 11'b000_0000_1000,
        ST_LW_WB  = 11'b000_0001_0000,
        ST_SW_MEM = 11'b000_0010_0000,
        ST_I_DONE = 11'b000_0100_0000,
        ST_EXEC   = 11'b000_1000_0000,
        ST_R_DONE = 11'b001_0000_0000,
        ST_BEQ    = 11'b010_0000_0000,
        ST_JUMP   = 11'b100_0000_0000
    } state_t;

    // Input beat
    typedef struct packed {
        logic [3:0] opcode;
        logic [2:0] funct;
    } in_t;

    // Result beat
    typedef struct packed {
        logic       pc_write;
        logic       addr_select;
        logic       mem_write;
        logic       ir_write;
        logic       mem_to_reg;
        logic       reg_write;
        logic       alu_src_a;
        logic [1:0] alu_src_b;
        logic [2:0] alu_op;
        logic [1:0] pc_source;
        logic       reg_dst;
        logic       branch;
    } out_t;

endpackage

`default_nettype wire

>>> hw/rtl/multicycle_cpu_control_fsm.sv
// Multicycle processor control unit: state register, control decode and result register.
// The control word for an input beat is registered and appears on m_data in the cycle after acceptance.
// Throughput: one beat per cycle unless m_ready stalls; state advances once per accepted beat.
// The result register frees whenever it is empty or being drained, so s_ready = !m_valid | m_ready.
// Reset (aresetn low, synchronous): state returns to fetch and the result register empties.
`default_nettype none

module multicycle_cpu_control_fsm
    import mcc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,

    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    state_t state_reg, state_next;
    out_t   res_next;
    out_t   m_data_reg;
    logic   m_valid_reg;
    logic   s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Control word of the present state and next-state selection
    always_comb begin
        res_next   = '0;
        state_next = ST_FETCH;
        unique case (state_reg)
            ST_FETCH: begin
                res_next.pc_write  = 1'b1;
                res_next.ir_write  = 1'b1;
                res_next.alu_src_b = SRCB_ONE;
                res_next.reg_dst   = 1'b1;
                state_next         = ST_DECODE;
            end
            ST_DECODE: begin
                res_next.alu_src_b = SRCB_IMM;
                res_next.reg_dst   = 1'b1;
                case (s_data.opcode)
                    OP_RTYPE:                 state_next = ST_EXEC;
                    OP_JUMP:                  state_next = ST_JUMP;
                    OP_BEQ:                   state_next = ST_BEQ;
                    OP_ADDI, OP_LW, OP_SW:    state_next = ST_ADDR;
                    default:                  state_next = ST_DECODE;
                endcase
            end
            ST_ADDR: begin
                res_next.alu_src_a = 1'b1;
                res_next.alu_src_b = SRCB_IMM;
                case (s_data.opcode)
                    OP_ADDI: state_next = ST_I_DONE;
                    OP_LW:   state_next = ST_LW_MEM;
                    OP_SW:   state_next = ST_SW_MEM;
                    default: state_next = ST_ADDR;
                endcase
            end
            ST_LW_MEM: begin
                res_next.addr_select = 1'b1;
                res_next.alu_src_a   = 1'b1;
                res_next.alu_src_b   = SRCB_IMM;
                state_next           = ST_LW_WB;
            end
            ST_LW_WB: begin
                res_next.mem_to_reg = 1'b1;
                res_next.reg_write  = 1'b1;
                res_next.alu_src_a  = 1'b1;
                res_next.alu_src_b  = SRCB_IMM;
            end
            ST_SW_MEM: begin
                res_next.addr_select = 1'b1;
                res_next.mem_write   = 1'b1;
                res_next.alu_src_a   = 1'b1;
                res_next.alu_src_b   = SRCB_IMM;
            end
            ST_I_DONE: begin
                res_next.reg_write = 1'b1;
                res_next.alu_src_a = 1'b1;
                res_next.alu_src_b = SRCB_IMM;
            end
            ST_EXEC: begin
                res_next.alu_src_a = 1'b1;
                res_next.alu_src_b = SRCB_REG;
                res_next.reg_dst   = 1'b1;
                // ALU operation follows funct for the supported codes
                case (s_data.funct)
                    ALU_OP_F2, ALU_OP_F4, ALU_OP_F5: res_next.alu_op = s_data.funct;
                    default:                         res_next.alu_op = ALU_OP_ADD;
                endcase
                state_next = ST_R_DONE;
            end
            ST_R_DONE: begin
                res_next.reg_write = 1'b1;
                res_next.alu_src_a = 1'b1;
                res_next.alu_src_b = SRCB_REG;
                res_next.reg_dst   = 1'b1;
                res_next.alu_op    = (s_data.funct == ALU_OP_F2) ? ALU_OP_F2 : ALU_OP_ADD;
            end
            ST_BEQ: begin
                res_next.alu_src_a = 1'b1;
                res_next.alu_src_b = SRCB_REG;
                res_next.alu_op    = ALU_OP_SUB;
                res_next.pc_source = PCS_BRANCH;
                res_next.branch    = 1'b1;
            end
            ST_JUMP: begin
                res_next.pc_write  = 1'b1;
                res_next.pc_source = PCS_JUMP;
            end
            default: begin
                res_next   = '0;
                state_next = ST_FETCH;
            end
        endcase
    end

    // State advances once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FETCH;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res_next;
        end
    end

    // Fetch is always followed by decode
    a_fetch_to_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_reg == ST_FETCH) |=> (state_reg == ST_DECODE))
        else $error("fetch did not advance to decode");

    // State only moves on an accepted beat
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(state_reg))
        else $error("state changed without an input beat");

    // An instruction load always comes with a PC update
    a_ir_with_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ir_write) |-> m_data.pc_write)
        else $error("ir_write without pc_write");

    // Memory writes use the ALU address
    a_store_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.mem_write) |-> m_data.addr_select)
        else $error("mem_write with PC address");

    // A beat accepted in the fetch state produces a fetch control word
    a_fetch_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && state_reg == ST_FETCH) |=> (m_valid && m_data.ir_write))
        else $error("fetch beat did not produce ir_write");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the multicycle control unit: directed table, then random beats.
`default_nettype none

module tb_top
    import mcc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int RAND_BEATS [3] = '{200, 200, 150};

    // Opcodes the decoder does not know
    localparam logic [3:0] OP_UNKNOWN_A = 4'd3;
    localparam logic [3:0] OP_UNKNOWN_B = 4'd7;
    localparam logic [2:0] FN_MIN = 3'd0;
    localparam logic [2:0] FN_MAX = 3'd7;

    // Control words that can be read off directly
    localparam out_t W_NONE = '0;
    localparam out_t W_FETCH = {1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, SRCB_ONE,
                                ALU_OP_ADD, PCS_ALU, 1'b1, 1'b0};
    localparam out_t W_DECODE = {7'b0, SRCB_IMM, ALU_OP_ADD, PCS_ALU, 1'b1, 1'b0};
    localparam out_t W_BEQ = {6'b0, 1'b1, SRCB_REG, ALU_OP_SUB, PCS_BRANCH, 1'b0, 1'b1};
    localparam out_t W_JUMP = {1'b1, 6'b0, SRCB_REG, ALU_OP_ADD, PCS_JUMP, 1'b0, 1'b0};

    // Controller state, binary coded
    typedef enum logic [3:0] {
        CS_FETCH  = 4'd0,
        CS_DECODE = 4'd1,
        CS_ADDR   = 4'd2,
        CS_LW_MEM = 4'd3,
        CS_LW_WB  = 4'd4,
        CS_SW_MEM = 4'd5,
        CS_I_DONE = 4'd6,
        CS_EXEC   = 4'd7,
        CS_R_DONE = 4'd8,
        CS_BEQ    = 4'd9,
        CS_JUMP   = 4'd10
    } ctrl_state_t;

    typedef struct packed {
        logic [3:0] opcode;
        logic [2:0] funct;
        logic       typed;
        out_t       word;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    // Shadow of the controller, advanced on every accepted input beat
    ctrl_state_t shadow_state;
    out_t        ctrl_word_q [$];
    logic        word_typed;
    out_t        typed_word;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_reqs;
    int hold_seen;
    int hold_left;
    int mismatch_cnt;
    int cycle_cnt;

    dir_row_t dir_tbl [25];

    multicycle_cpu_control_fsm DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Control signals driven in a given state
    function automatic out_t control_word(ctrl_state_t st, logic [2:0] fn);
        out_t w;
        w = '0;
        case (st)
            CS_FETCH: begin
                w.pc_write  = 1'b1;
                w.ir_write  = 1'b1;
                w.alu_src_b = SRCB_ONE;
                w.reg_dst   = 1'b1;
            end
            CS_DECODE: begin
                w.alu_src_b = SRCB_IMM;
                w.reg_dst   = 1'b1;
            end
            CS_ADDR: begin
                w.alu_src_a = 1'b1;
                w.alu_src_b = SRCB_IMM;
            end
            CS_LW_MEM: begin
                w.addr_select = 1'b1;
                w.alu_src_a   = 1'b1;
                w.alu_src_b   = SRCB_IMM;
            end
            CS_LW_WB: begin
                w.mem_to_reg = 1'b1;
                w.reg_write  = 1'b1;
                w.alu_src_a  = 1'b1;
                w.alu_src_b  = SRCB_IMM;
            end
            CS_SW_MEM: begin
                w.addr_select = 1'b1;
                w.mem_write   = 1'b1;
                w.alu_src_a   = 1'b1;
                w.alu_src_b   = SRCB_IMM;
            end
            CS_I_DONE: begin
                w.reg_write = 1'b1;
                w.alu_src_a = 1'b1;
                w.alu_src_b = SRCB_IMM;
            end
            CS_EXEC: begin
                w.alu_src_a = 1'b1;
                w.alu_src_b = SRCB_REG;
                w.reg_dst   = 1'b1;
                // execute passes funct through only for the three coded operations
                if (fn == ALU_OP_F2 || fn == ALU_OP_F4 || fn == ALU_OP_F5) begin
                    w.alu_op = fn;
                end else begin
                    w.alu_op = ALU_OP_ADD;
                end
            end
            CS_R_DONE: begin
                w.reg_write = 1'b1;
                w.alu_src_a = 1'b1;
                w.alu_src_b = SRCB_REG;
                w.reg_dst   = 1'b1;
                w.alu_op    = (fn == ALU_OP_F2) ? ALU_OP_F2 : ALU_OP_ADD;
            end
            CS_BEQ: begin
                w.alu_src_a = 1'b1;
                w.alu_src_b = SRCB_REG;
                w.alu_op    = ALU_OP_SUB;
                w.pc_source = PCS_BRANCH;
                w.branch    = 1'b1;
            end
            CS_JUMP: begin
                w.pc_write  = 1'b1;
                w.pc_source = PCS_JUMP;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

    // State transition; unknown opcodes hold decode and address calculation
    function automatic ctrl_state_t next_ctrl_state(ctrl_state_t st, logic [3:0] op);
        case (st)
            CS_FETCH: return CS_DECODE;
            CS_DECODE: begin
                case (op)
                    OP_RTYPE: return CS_EXEC;
                    OP_JUMP:  return CS_JUMP;
                    OP_ADDI:  return CS_ADDR;
                    OP_BEQ:   return CS_BEQ;
                    OP_LW:    return CS_ADDR;
                    OP_SW:    return CS_ADDR;
                    default:  return st;
                endcase
            end
            CS_ADDR: begin
                case (op)
                    OP_ADDI: return CS_I_DONE;
                    OP_LW:   return CS_LW_MEM;
                    OP_SW:   return CS_SW_MEM;
                    default: return st;
                endcase
            end
            CS_LW_MEM: return CS_LW_WB;
            CS_EXEC:   return CS_R_DONE;
            default:   return CS_FETCH;
        endcase
    endfunction

    function automatic logic [3:0] pick_opcode();
        case ($urandom_range(5))
            0:       return OP_RTYPE;
            1:       return OP_JUMP;
            2:       return OP_ADDI;
            3:       return OP_BEQ;
            4:       return OP_LW;
            default: return OP_SW;
        endcase
    endfunction

    task automatic show_word(string tag, out_t w);
        $write("  %s pcw=%0d adr=%0d memw=%0d irw=%0d m2r=%0d regw=%0d",
               tag, w.pc_write, w.addr_select, w.mem_write, w.ir_write, w.mem_to_reg,
               w.reg_write);
        $display(" srca=%0d srcb=%0d aluop=%0d pcsrc=%0d rdst=%0d br=%0d",
                 w.alu_src_a, w.alu_src_b, w.alu_op, w.pc_source, w.reg_dst, w.branch);
    endtask

    // Offer one beat after a random gap; return at the falling edge after acceptance
    task automatic send_beat(in_t d, logic typed, out_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data     = d;
        word_typed = typed;
        typed_word = w;
        s_valid    = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (ctrl_word_q.size() != 0) @(negedge aclk);
    endtask

    // Predict on input beats, check on result beats
    always @(posedge aclk) begin
        out_t exp_w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (word_typed) begin
                    ctrl_word_q.push_back(typed_word);
                end else begin
                    ctrl_word_q.push_back(control_word(shadow_state, s_data.funct));
                end
                shadow_state = next_ctrl_state(shadow_state, s_data.opcode);
            end
            if (m_valid && m_ready) begin
                if (ctrl_word_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10) begin
                        $display("result beat with nothing expected at cycle %0d", cycle_cnt);
                        show_word("got", m_data);
                    end
                end else begin
                    exp_w = ctrl_word_q.pop_front();
                    if (m_data.pc_write !== exp_w.pc_write
                            || m_data.addr_select !== exp_w.addr_select
                            || m_data.mem_write !== exp_w.mem_write
                            || m_data.ir_write !== exp_w.ir_write
                            || m_data.mem_to_reg !== exp_w.mem_to_reg
                            || m_data.reg_write !== exp_w.reg_write
                            || m_data.alu_src_a !== exp_w.alu_src_a
                            || m_data.alu_src_b !== exp_w.alu_src_b
                            || m_data.alu_op !== exp_w.alu_op
                            || m_data.pc_source !== exp_w.pc_source
                            || m_data.reg_dst !== exp_w.reg_dst
                            || m_data.branch !== exp_w.branch) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("control word mismatch at cycle %0d", cycle_cnt);
                            show_word("exp", exp_w);
                            show_word("got", m_data);
                        end
                    end
                end
            end
        end
    end

    // Receiver: random ready, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt,
                     ctrl_word_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        in_t        beat;
        logic [3:0] instr_op;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        word_typed    = 1'b0;
        typed_word    = '0;
        shadow_state  = CS_FETCH;
        send_idle_pct = 15;
        recv_idle_pct = 59;
        hold_reqs     = 0;
        hold_seen     = 0;
        hold_left     = 0;
        mismatch_cnt  = 0;
        cycle_cnt     = 0;
        instr_op      = OP_RTYPE;

        // Directed walk through every path and both stall cases
        dir_tbl[0]  = {OP_RTYPE, FN_MAX, 1'b1, W_FETCH};       // fetch right after reset
        dir_tbl[1]  = {OP_UNKNOWN_A, FN_MIN, 1'b1, W_DECODE};  // decode holds on unknown op
        dir_tbl[2]  = {OP_RTYPE, ALU_OP_F4, 1'b0, W_NONE};
        dir_tbl[3]  = {OP_SW, ALU_OP_F4, 1'b0, W_NONE};        // execute
        dir_tbl[4]  = {OP_SW, ALU_OP_F2, 1'b0, W_NONE};        // R-type completion
        dir_tbl[5]  = {OP_SW, FN_MIN, 1'b1, W_FETCH};
        dir_tbl[6]  = {OP_SW, FN_MAX, 1'b0, W_NONE};
        dir_tbl[7]  = {OP_UNKNOWN_B, FN_MIN, 1'b0, W_NONE};    // address calc holds
        dir_tbl[8]  = {OP_SW, FN_MIN, 1'b0, W_NONE};
        dir_tbl[9]  = {OP_RTYPE, FN_MAX, 1'b0, W_NONE};        // store memory
        dir_tbl[10] = {OP_LW, FN_MAX, 1'b0, W_NONE};
        dir_tbl[11] = {OP_LW, FN_MIN, 1'b0, W_NONE};
        dir_tbl[12] = {OP_LW, ALU_OP_F5, 1'b0, W_NONE};
        dir_tbl[13] = {OP_LW, FN_MAX, 1'b0, W_NONE};
        dir_tbl[14] = {OP_LW, FN_MIN, 1'b0, W_NONE};
        dir_tbl[15] = {OP_ADDI, FN_MIN, 1'b0, W_NONE};
        dir_tbl[16] = {OP_ADDI, FN_MAX, 1'b0, W_NONE};
        dir_tbl[17] = {OP_ADDI, FN_MIN, 1'b0, W_NONE};
        dir_tbl[18] = {OP_ADDI, FN_MAX, 1'b0, W_NONE};
        dir_tbl[19] = {OP_BEQ, FN_MIN, 1'b0, W_NONE};
        dir_tbl[20] = {OP_BEQ, FN_MAX, 1'b0, W_NONE};
        dir_tbl[21] = {OP_BEQ, FN_MIN, 1'b1, W_BEQ};
        dir_tbl[22] = {OP_JUMP, FN_MAX, 1'b0, W_NONE};
        dir_tbl[23] = {OP_JUMP, FN_MIN, 1'b0, W_NONE};
        dir_tbl[24] = {OP_JUMP, FN_MAX, 1'b1, W_JUMP};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tbl[i]) begin
            beat.opcode = dir_tbl[i].opcode;
            beat.funct  = dir_tbl[i].funct;
            send_beat(beat, dir_tbl[i].typed, dir_tbl[i].word);
        end
        // sender pauses until the pipe is empty
        wait_drained();

        // Random instruction streams, with occasional noise opcodes
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 15 : 0;
            for (int n = 0; n < RAND_BEATS[phase]; n++) begin
                if (phase == 2 && n == 60) begin
                    hold_reqs++;
                end
                if (shadow_state == CS_FETCH) begin
                    instr_op = pick_opcode();
                end
                // a noise beat in decode may divert a non-memory instruction here
                if (shadow_state == CS_ADDR && instr_op != OP_ADDI && instr_op != OP_LW
                        && instr_op != OP_SW) begin
                    case ($urandom_range(2))
                        0:       instr_op = OP_ADDI;
                        1:       instr_op = OP_LW;
                        default: instr_op = OP_SW;
                    endcase
                end
                beat.opcode = ($urandom_range(99) < 10) ? 4'($urandom_range(15)) : instr_op;
                beat.funct  = 3'($urandom_range(7));
                send_beat(beat, 1'b0, W_NONE);
            end
            wait_drained();
        end

        repeat (5) @(negedge aclk);
        if (mismatch_cnt == 0 && ctrl_word_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
